// ----- rtl/nbsd_pkg.sv -----
// Shared types and constants for the NAL byte-stream deframer.
// Holds the result item kinds, the parser phase codes and the item and batch records.
// No dependencies.
package nbsd_pkg;

   // Kind of one result item as it leaves the block.
   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   // Parser phase, one-hot.
   typedef enum logic [2:0] {
      PH_SEARCH  = 3'b001,
      PH_HEADER  = 3'b010,
      PH_PAYLOAD = 3'b100
   } phase_type;

   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONE  = 8'h01;
   localparam logic [7:0] BYTE_EPB  = 8'h03;

   localparam int MaxItems  = 4;   // results one input byte can cause
   localparam int QueueSize = 5;   // one waiting item plus a full batch

   // One result item: data is the header byte, the payload byte or zero.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } item_type;

   // All the results of one input byte, in order, slot 0 first.
   typedef struct packed {
      logic [2:0]                  count;
      item_type [MaxItems-1:0]     items;
   } batch_type;

endpackage

// ----- rtl/nbsd_parse.sv -----
// Start-code hunt, header split and emulation-prevention removal for one byte.
// Holds the phase and held-zero registers and builds the batch of results for a byte.
// Depends on nbsd_pkg.
module nbsd_parse
   import nbsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] stream_byte,
   input  logic       stream_end,
   output batch_type  batch
);

   phase_type  phase_ff, phase_in;
   logic [1:0] zeros_ff, zeros_in;

   logic       n_hdr;
   logic [1:0] n_zero;
   logic       n_pay;
   logic       n_end;
   logic [2:0] lim_hdr, lim_zero, lim_pay, total;

   always_comb begin
      phase_in = phase_ff;
      zeros_in = zeros_ff;
      n_hdr    = 1'b0;
      n_zero   = 2'd0;
      n_pay    = 1'b0;
      n_end    = 1'b0;
      unique case (phase_ff)
         PH_SEARCH: begin
            if (stream_byte == BYTE_ZERO) begin
               if (zeros_ff != 2'd3) begin
                  zeros_in = zeros_ff + 2'd1;
               end
            end else if (stream_byte == BYTE_ONE && zeros_ff[1]) begin
               phase_in = PH_HEADER;
               zeros_in = 2'd0;
            end else begin
               zeros_in = 2'd0;
            end
         end
         PH_HEADER: begin
            n_hdr    = 1'b1;
            n_end    = stream_end;
            phase_in = PH_PAYLOAD;
            zeros_in = 2'd0;
         end
         PH_PAYLOAD: begin
            if (zeros_ff[1] && stream_byte == BYTE_ZERO) begin
               n_end    = 1'b1;
               phase_in = PH_SEARCH;
               zeros_in = 2'd3;
            end else if (zeros_ff[1] && stream_byte == BYTE_ONE) begin
               n_end    = 1'b1;
               phase_in = PH_HEADER;
               zeros_in = 2'd0;
            end else if (zeros_ff[1] && stream_byte == BYTE_EPB) begin
               // The emulation-prevention byte is dropped; the held zeros go out.
               n_zero   = zeros_ff;
               n_end    = stream_end;
               zeros_in = 2'd0;
            end else if (stream_byte == BYTE_ZERO) begin
               if (stream_end) begin
                  n_zero = zeros_ff + 2'd1;
                  n_end  = 1'b1;
               end
               zeros_in = zeros_ff + 2'd1;
            end else begin
               n_zero   = zeros_ff;
               n_pay    = 1'b1;
               n_end    = stream_end;
               zeros_in = 2'd0;
            end
         end
         default: begin
            phase_in = PH_SEARCH;
            zeros_in = 2'd0;
         end
      endcase
      if (stream_end) begin
         phase_in = PH_SEARCH;
         zeros_in = 2'd0;
      end
   end

   // Items are laid out as header, held zeros, payload byte, end item.
   assign lim_hdr  = {2'b00, n_hdr};
   assign lim_zero = lim_hdr + {1'b0, n_zero};
   assign lim_pay  = lim_zero + {2'b00, n_pay};
   assign total    = lim_pay + {2'b00, n_end};

   always_comb begin
      batch.count = total;
      for (int i = 0; i < MaxItems; i++) begin
         if (3'(i) < lim_hdr) begin
            batch.items[i].kind = KIND_HEADER;
            batch.items[i].data = stream_byte;
         end else if (3'(i) < lim_zero) begin
            batch.items[i].kind = KIND_PAYLOAD;
            batch.items[i].data = BYTE_ZERO;
         end else if (3'(i) < lim_pay) begin
            batch.items[i].kind = KIND_PAYLOAD;
            batch.items[i].data = stream_byte;
         end else begin
            batch.items[i].kind = KIND_END;
            batch.items[i].data = BYTE_ZERO;
         end
         batch.items[i].last = (3'(i) == total - 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         zeros_ff <= 2'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         zeros_ff <= zeros_in;
      end
   end

   a_batch_bound: assert property (@(posedge clock) disable iff (reset)
      fire |-> total <= 3'(MaxItems))
      else $error("batch larger than four items");
   a_search_silent: assert property (@(posedge clock) disable iff (reset)
      (fire && phase_ff == PH_SEARCH) |-> total == 3'd0)
      else $error("result produced while hunting for a start code");
   a_payload_zeros: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> zeros_ff != 2'd3)
      else $error("more than two zeros held inside a unit");
   a_header_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> zeros_ff == 2'd0)
      else $error("zeros held while expecting a header byte");

endmodule

// ----- rtl/nbsd_outq.sv -----
// Result queue of the deframer: takes a whole batch in a single push, hands out one item a beat.
// Slot 0 is the output register; accepts a batch while at most one item waits.
// Depends on nbsd_pkg.
module nbsd_outq
   import nbsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  batch_type batch,
   output logic      space,
   output logic      head_valid,
   output item_type  head,
   input  logic      head_ready
);

   item_type [QueueSize-1:0] slots_ff, slots_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [2:0] base;
   logic [2:0] off;
   logic       pop;

   assign pop        = head_valid && head_ready;
   assign head_valid = (cnt_ff != 3'd0);
   assign head       = slots_ff[0];
   assign space      = (cnt_ff <= 3'd1);
   assign base       = cnt_ff - {2'b00, pop};
   assign cnt_in     = base + (push ? batch.count : 3'd0);

   always_comb begin
      slots_in = slots_ff;
      off      = 3'd0;
      if (pop) begin
         for (int i = 0; i < QueueSize - 1; i++) begin
            slots_in[i] = slots_ff[i+1];
         end
      end
      if (push) begin
         for (int i = 0; i < QueueSize; i++) begin
            off = 3'(i) - base;
            if (3'(i) >= base && off < batch.count) begin
               slots_in[i] = batch.items[off[1:0]];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(QueueSize))
      else $error("result queue overflow");
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (push && batch.count != 3'd0) |=> head_valid)
      else $error("pushed batch not presented");
   a_lone_last: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 3'd1 |-> slots_ff[0].last)
      else $error("single waiting item does not close its batch");

endmodule

// ----- rtl/nal_byte_stream_deframer_core.sv -----
// Top level of the NAL byte-stream deframer: stream ports, parser and result queue.
// Results enter the result queue registers at the edge that accepts their byte on req.
// Throughput: one byte per cycle while each byte gives at most one result and rsp
// is ready; a byte giving several results takes a beat per result on the single output port.
// Reset (synchronous, active high) returns to start-code hunting and empties the queue.
// Depends on nbsd_pkg, nbsd_parse and nbsd_outq.
module nal_byte_stream_deframer_core
   import nbsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   input  logic        req_tlast,   // stream_end

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] payload_byte, [8] forbidden_bit,
                                    // [10:9] ref_level, [15:11] unit_type
   output logic [1:0]  rsp_tuser,   // [1:0] item_kind
   output logic        rsp_tlast    // run_last
);

   // A byte is taken whenever the queue holds at most one item, so the parser's
   // state moves on at the same edge the batch for that byte enters the queue.
   // The ready path depends on the queue count only, never on rsp_tready.
   logic      req_fire;
   batch_type batch;
   item_type  head;
   logic      is_hdr;
   logic      is_pay;

   assign req_fire = req_tvalid && req_tready;

   nbsd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .fire        (req_fire),
      .stream_byte (req_tdata),
      .stream_end  (req_tlast),
      .batch       (batch)
   );

   nbsd_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (req_fire),
      .batch      (batch),
      .space      (req_tready),
      .head_valid (rsp_tvalid),
      .head       (head),
      .head_ready (rsp_tready)
   );

   // The queue stores one data byte per item; it is shown in the payload field for
   // payload beats and split into the header fields for header beats.
   assign is_hdr = (head.kind == KIND_HEADER);
   assign is_pay = (head.kind == KIND_PAYLOAD);

   assign rsp_tdata[7:0]   = is_pay ? head.data : 8'h00;
   assign rsp_tdata[8]     = is_hdr ? head.data[7] : 1'b0;
   assign rsp_tdata[10:9]  = is_hdr ? head.data[6:5] : 2'b00;
   assign rsp_tdata[15:11] = is_hdr ? head.data[4:0] : 5'd0;
   assign rsp_tuser        = head.kind;
   assign rsp_tlast        = head.last;

endmodule

// ----- bench/tb_nal_byte_stream_deframer_core.sv -----
// Self-checking testbench for nal_byte_stream_deframer_core: start-code hunting, header
// decoding, emulation-prevention removal and unit ends, checked beat by beat on rsp.
// Depends on nbsd_pkg and nal_byte_stream_deframer_core.
module tb_nal_byte_stream_deframer_core
   import nbsd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int MAX_REPORTS     = 10;

   // One result beat as the deframer should present it.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload;
      logic       forbidden;
      logic [1:0] ref_level;
      logic [4:0] unit_type;
      logic       run_last;
   } nal_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] stream_byte
   logic        req_tlast = 1'b0; // stream_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [7:0] payload_byte, [8] forbidden_bit,
                                  // [10:9] ref_level, [15:11] unit_type
   logic [1:0]  rsp_tuser;        // [1:0] item_kind
   logic        rsp_tlast;        // run_last

   // Mirror of the parser state, updated on every accepted input beat.
   phase_type   parse_phase = PH_SEARCH;
   logic [1:0]  zero_run    = 2'd0;

   nal_item_type expected_items[$];
   int          mismatch_count = 0;
   int          parsed_bytes   = 0;
   int          cycle_count    = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          hold_off_token = 0;

   nal_byte_stream_deframer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // A run that has not finished by the limit is taken as hung.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Builds a result beat; only payload beats carry a data byte.
   function automatic nal_item_type plain_item(logic [1:0] kind, logic [7:0] b);
      nal_item_type it;
      it = '0;
      it.kind = kind;
      if (kind == KIND_PAYLOAD) it.payload = b;
      return it;
   endfunction

   // The header byte splits into forbidden bit, reference level and unit type.
   function automatic nal_item_type header_item(logic [7:0] hdr);
      nal_item_type it;
      it = '0;
      it.kind      = KIND_HEADER;
      it.forbidden = hdr[7];
      it.ref_level = hdr[6:5];
      it.unit_type = hdr[4:0];
      return it;
   endfunction

   // Works out the result beats of one stream byte and queues them in order. The
   // zeros held back inside a unit are released before whatever ends their run.
   task automatic deframe_byte(input logic [7:0] b, input logic eos);
      nal_item_type batch[$];
      case (parse_phase)
         PH_SEARCH: begin
            if (b == BYTE_ZERO) begin
               if (zero_run != 2'd3) zero_run++;
            end else if (b == BYTE_ONE && zero_run >= 2'd2) begin
               parse_phase = PH_HEADER;
               zero_run    = 2'd0;
            end else begin
               zero_run = 2'd0;
            end
         end
         PH_HEADER: begin
            batch.push_back(header_item(b));
            parse_phase = PH_PAYLOAD;
            zero_run    = 2'd0;
            if (eos) batch.push_back(plain_item(KIND_END, 8'h00));
         end
         default: begin
            if (zero_run >= 2'd2 && b == BYTE_ZERO) begin
               // Three zeros close the unit and already count towards the next start code.
               batch.push_back(plain_item(KIND_END, 8'h00));
               parse_phase = PH_SEARCH;
               zero_run    = 2'd3;
            end else if (zero_run >= 2'd2 && b == BYTE_ONE) begin
               batch.push_back(plain_item(KIND_END, 8'h00));
               parse_phase = PH_HEADER;
               zero_run    = 2'd0;
            end else if (zero_run >= 2'd2 && b == BYTE_EPB) begin
               // Emulation prevention: the zeros are real data, the 03 is dropped.
               for (; zero_run != 2'd0; zero_run--)
                  batch.push_back(plain_item(KIND_PAYLOAD, BYTE_ZERO));
            end else if (b == BYTE_ZERO) begin
               zero_run++;
            end else begin
               for (; zero_run != 2'd0; zero_run--)
                  batch.push_back(plain_item(KIND_PAYLOAD, BYTE_ZERO));
               batch.push_back(plain_item(KIND_PAYLOAD, b));
            end
            if (eos && parse_phase == PH_PAYLOAD) begin
               for (; zero_run != 2'd0; zero_run--)
                  batch.push_back(plain_item(KIND_PAYLOAD, BYTE_ZERO));
               batch.push_back(plain_item(KIND_END, 8'h00));
            end
         end
      endcase
      if (eos) begin
         parse_phase = PH_SEARCH;
         zero_run    = 2'd0;
      end
      if (batch.size() > 0) batch[batch.size()-1].run_last = 1'b1;
      foreach (batch[i]) expected_items.push_back(batch[i]);
   endtask

   // Offers one byte from a falling edge and returns at the falling edge after it was
   // taken. The valid stays high, so back-to-back bytes need no extra assignment.
   task automatic send_byte(input logic [7:0] b, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tlast  = eos;
      do @(posedge clock); while (!req_tready);
      if (parse_phase != PH_SEARCH) parsed_bytes++;
      deframe_byte(b, eos);
      @(negedge clock);
   endtask

   // Stops offering and waits for every queued result, plus a little slack.
   task automatic wait_until_drained();
      req_tvalid = 1'b0;
      while (expected_items.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Payload bytes lean heavily on zeros, 01 and 03 so that the escape and end rules fire.
   function automatic logic [7:0] pick_payload_byte();
      int r;
      r = $urandom_range(99);
      if (r < 30) return BYTE_ZERO;
      if (r < 38) return BYTE_EPB;
      if (r < 44) return BYTE_ONE;
      if (r < 48) return 8'h02;
      return 8'($urandom_range(255));
   endfunction

   // Sends one unit with a random start code, header and payload; now and then a broken
   // start code or plain noise instead.
   task automatic send_unit();
      int         r;
      int         lead;
      int         len;
      logic [7:0] b;
      logic       eos;
      r = $urandom_range(99);
      if (r < 12) begin
         repeat ($urandom_range(1, 6))
            send_byte(8'($urandom_range(255)), $urandom_range(99) < 10);
         return;
      end
      lead = (r < 18) ? $urandom_range(0, 1) : $urandom_range(2, 4);
      repeat (lead) send_byte(BYTE_ZERO, 1'b0);
      send_byte(BYTE_ONE, 1'b0);
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
      send_byte(8'($urandom_range(255)), len == 0 && $urandom_range(99) < 15);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 8) begin
            send_byte(BYTE_ZERO, 1'b0);
            send_byte(BYTE_ZERO, 1'b0);
            send_byte(BYTE_EPB, 1'b0);
         end
         b   = pick_payload_byte();
         eos = (i == len - 1) ? ($urandom_range(99) < 12) : ($urandom_range(99) < 2);
         send_byte(b, eos);
      end
   endtask

   // Hand-picked stream: each entry is {stream_end, byte}.
   task automatic run_directed_cases();
      logic [8:0] seq[$];
      seq = '{
         // Four-byte start code, header with the forbidden bit set, ordinary byte.
         9'h000, 9'h000, 9'h000, 9'h001, 9'h0E5, 9'h0FF,
         // A lone zero before 03 leaves the 03 as data; 00 00 03 loses its 03.
         9'h000, 9'h003, 9'h000, 9'h000, 9'h003,
         // 00 00 02 releases the zeros; 00 00 00 ends the unit and counts as a start.
         9'h000, 9'h000, 9'h002, 9'h000, 9'h000, 9'h000, 9'h001, 9'h00E,
         // 00 00 01 ends a unit straight into the next header, type 20.
         9'h000, 9'h000, 9'h001, 9'h014,
         // An escape byte that is also the last of the stream.
         9'h000, 9'h000, 9'h103,
         // Stream ends right after a header.
         9'h000, 9'h000, 9'h001, 9'h17F,
         // Stream ends just after a start code, then while searching.
         9'h000, 9'h000, 9'h101, 9'h100,
         // Stream ends inside a unit with two zeros held back.
         9'h000, 9'h000, 9'h001, 9'h041, 9'h000, 9'h100
      };
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      foreach (seq[i]) send_byte(seq[i][7:0], seq[i][8]);
      wait_until_drained();
   endtask

   // Random units under one idling mix, until enough bytes have reached the parser.
   task automatic run_random_units(input int n, input int send_pct, input int recv_pct);
      int target;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      target         = parsed_bytes + n;
      while (parsed_bytes < target) send_unit();
      wait_until_drained();
   endtask

   // The receiver holds off for a long stretch while bytes keep coming, so the result
   // queue fills and the input has to stall.
   task automatic run_output_hold_off();
      int target;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      @(posedge clock);
      hold_off_token++;
      @(negedge clock);
      target = parsed_bytes + 30;
      while (parsed_bytes < target) send_unit();
      wait_until_drained();
   endtask

   // Receiver: random stalls at the set rate, or a counted hold-off when asked for one.
   always @(negedge clock) begin
      static int hold_left  = 0;
      static int token_seen = 0;
      if (hold_off_token != token_seen) begin
         token_seen = hold_off_token;
         hold_left  = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Every accepted result beat is matched against the oldest expectation.
   always @(posedge clock) begin
      nal_item_type got;
      nal_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind      = rsp_tuser;
         got.payload   = rsp_tdata[7:0];
         got.forbidden = rsp_tdata[8];
         got.ref_level = rsp_tdata[10:9];
         got.unit_type = rsp_tdata[15:11];
         got.run_last  = rsp_tlast;
         if (expected_items.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected beat kind %0d data %02h f %0b ref %0d type %0d last %0b",
                        $realtime, got.kind, got.payload, got.forbidden, got.ref_level,
                        got.unit_type, got.run_last);
         end else begin
            want = expected_items.pop_front();
            if (got.kind !== want.kind || got.payload !== want.payload ||
                got.forbidden !== want.forbidden || got.ref_level !== want.ref_level ||
                got.unit_type !== want.unit_type || got.run_last !== want.run_last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: mismatch, expected kind %0d data %02h f %0b ref %0d type %0d last %0b",
                           $realtime, want.kind, want.payload, want.forbidden,
                           want.ref_level, want.unit_type, want.run_last);
                  $display("   got kind %0d data %02h f %0b ref %0d type %0d last %0b",
                           got.kind, got.payload, got.forbidden, got.ref_level,
                           got.unit_type, got.run_last);
               end
            end
         end
      end
   end

   initial begin
      repeat (12) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      run_directed_cases();
      run_random_units(45, 0, 0);
      run_random_units(45, 69, 0);
      run_random_units(45, 0, 69);
      run_random_units(45, 31, 31);
      run_output_hold_off();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && expected_items.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/nbsd_pkg.sv
rtl/nbsd_parse.sv
rtl/nbsd_outq.sv
rtl/nal_byte_stream_deframer_core.sv
bench/tb_nal_byte_stream_deframer_core.sv
